### src/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue RTL.
// Self-contained; included by deq_back, the module that carries assertions.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// cond must hold at every clock edge outside reset
`define DEQ_ASSERT(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/deq_pkg.sv
// Package for the double-ended queue: sizes, codes, transaction and link types.
// No dependencies.
`default_nettype none

package deq_pkg;

   // DEPTH must be a power of two
   localparam int DEPTH       = 1024;
   localparam int DATA_WIDTH  = 32;
   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int CNT_WIDTH   = PTR_WIDTH + 1;
   localparam int OP_WIDTH    = 4;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_FRONT = 4'd0,
      OP_PUSH_BACK  = 4'd1,
      OP_POP_FRONT  = 4'd2,
      OP_POP_BACK   = 4'd3,
      OP_READ_FRONT = 4'd4,
      OP_READ_BACK  = 4'd5,
      OP_READ_INDEX = 4'd6,
      OP_RESIZE     = 4'd7,
      OP_CLEAR      = 4'd8
   } op_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_POP,
      CMD_READ,
      CMD_RESIZE,
      CMD_CLEAR,
      CMD_NOP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      RD_FRONT,
      RD_BACK,
      RD_INDEX
   } read_sel_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_FILL
   } back_state_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   operation;
      logic [DATA_WIDTH-1:0] value;
      logic [CNT_WIDTH-1:0]  index;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_value;
      status_type            status;
      logic [CNT_WIDTH-1:0]  count;
      logic                  is_empty;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic                  at_back;
      read_sel_type          read_sel;
      logic [DATA_WIDTH-1:0] value;
      logic [CNT_WIDTH-1:0]  index;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

endpackage

`default_nettype wire

### src/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/deq_front.sv
// Front end: takes transactions, classifies the operation, holds a short queue.
// Depends on deq_pkg.
`default_nettype none

module deq_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire deq_pkg::req_type req_data,
   output deq_pkg::cmd_link_type link,
   input  wire logic             cmd_pop
);

   localparam int QPTR_WIDTH = $clog2(deq_pkg::QUEUE_DEPTH);
   localparam int LVL_WIDTH  = $clog2(deq_pkg::QUEUE_DEPTH + 1);

   deq_pkg::cmd_type      slot_ff [deq_pkg::QUEUE_DEPTH];
   deq_pkg::cmd_type      cmd_in;
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_WIDTH-1:0]  level_ff, level_in;
   logic                  accept;

   assign busy   = (level_ff == LVL_WIDTH'(deq_pkg::QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      cmd_in.kind     = deq_pkg::CMD_NOP;
      cmd_in.at_back  = 1'b0;
      cmd_in.read_sel = deq_pkg::RD_FRONT;
      cmd_in.value    = req_data.value;
      cmd_in.index    = req_data.index;
      unique case (req_data.operation)
         deq_pkg::OP_PUSH_FRONT: cmd_in.kind = deq_pkg::CMD_PUSH;
         deq_pkg::OP_PUSH_BACK: begin
            cmd_in.kind    = deq_pkg::CMD_PUSH;
            cmd_in.at_back = 1'b1;
         end
         deq_pkg::OP_POP_FRONT: cmd_in.kind = deq_pkg::CMD_POP;
         deq_pkg::OP_POP_BACK: begin
            cmd_in.kind    = deq_pkg::CMD_POP;
            cmd_in.at_back = 1'b1;
         end
         deq_pkg::OP_READ_FRONT: cmd_in.kind = deq_pkg::CMD_READ;
         deq_pkg::OP_READ_BACK: begin
            cmd_in.kind     = deq_pkg::CMD_READ;
            cmd_in.read_sel = deq_pkg::RD_BACK;
         end
         deq_pkg::OP_READ_INDEX: begin
            cmd_in.kind     = deq_pkg::CMD_READ;
            cmd_in.read_sel = deq_pkg::RD_INDEX;
         end
         deq_pkg::OP_RESIZE: cmd_in.kind = deq_pkg::CMD_RESIZE;
         deq_pkg::OP_CLEAR:  cmd_in.kind = deq_pkg::CMD_CLEAR;
         default:            cmd_in.kind = deq_pkg::CMD_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      level_in  = level_ff + LVL_WIDTH'(accept) - LVL_WIDTH'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   assign link.valid = (level_ff != '0);
   assign link.cmd   = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### src/deq_back.sv
// Back end: executes queued commands against the entry RAM, drives results.
// Depends on deq_pkg, deq_ram and double_ended_queue_macros.svh.
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire deq_pkg::cmd_link_type link,
   output logic                       cmd_pop,
   output logic                       rsp_valid,
   output deq_pkg::rsp_type           rsp_data
);

   localparam int PW = deq_pkg::PTR_WIDTH;
   localparam int CW = deq_pkg::CNT_WIDTH;
   localparam int DW = deq_pkg::DATA_WIDTH;

   deq_pkg::back_state_type state_ff, state_in;
   logic [PW-1:0]           front_ff, front_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic [CW-1:0]           target_ff, target_in;
   logic [DW-1:0]           fill_value_ff, fill_value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    ram_we, ram_re;
   logic [PW-1:0]           ram_waddr, ram_raddr, rd_offset;
   logic [DW-1:0]           ram_wdata, ram_rdata;
   deq_pkg::status_type     status;
   logic                    is_full, is_empty;

   deq_ram #(
      .WIDTH(DW),
      .DEPTH(deq_pkg::DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign is_full  = (count_ff == CW'(deq_pkg::DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      target_in     = target_ff;
      fill_value_in = fill_value_ff;
      rsp_valid_in  = 1'b0;
      status        = deq_pkg::ST_OK;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = front_ff + count_ff[PW-1:0];
      ram_wdata     = link.cmd.value;
      ram_re        = 1'b0;
      unique case (link.cmd.read_sel)
         deq_pkg::RD_BACK:  rd_offset = PW'(count_ff - CW'(1));
         deq_pkg::RD_INDEX: rd_offset = link.cmd.index[PW-1:0];
         default:           rd_offset = '0;
      endcase
      ram_raddr     = front_ff + rd_offset;

      unique case (state_ff)
         deq_pkg::BK_IDLE: begin
            if (link.valid) begin
               cmd_pop = 1'b1;
               unique case (link.cmd.kind)
                  deq_pkg::CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        status = deq_pkg::ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (!link.cmd.at_back) begin
                           front_in  = front_ff - PW'(1);
                           ram_waddr = front_ff - PW'(1);
                        end
                     end
                  end
                  deq_pkg::CMD_POP: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        status = deq_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (!link.cmd.at_back) begin
                           front_in = front_ff + PW'(1);
                        end
                     end
                  end
                  deq_pkg::CMD_READ: begin
                     if (is_empty) begin
                        rsp_valid_in = 1'b1;
                        status       = deq_pkg::ST_EMPTY;
                     end else if (link.cmd.read_sel == deq_pkg::RD_INDEX &&
                                  link.cmd.index >= count_ff) begin
                        rsp_valid_in = 1'b1;
                        status       = deq_pkg::ST_RANGE;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = deq_pkg::BK_READ;
                     end
                  end
                  deq_pkg::CMD_RESIZE: begin
                     if (link.cmd.index > CW'(deq_pkg::DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        status       = deq_pkg::ST_FULL;
                     end else if (link.cmd.index <= count_ff) begin
                        rsp_valid_in = 1'b1;
                        count_in     = link.cmd.index;
                     end else begin
                        fill_in       = count_ff;
                        target_in     = link.cmd.index;
                        fill_value_in = link.cmd.value;
                        state_in      = deq_pkg::BK_FILL;
                     end
                  end
                  deq_pkg::CMD_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         deq_pkg::BK_READ: begin
            rsp_valid_in = 1'b1;
            state_in     = deq_pkg::BK_IDLE;
         end
         deq_pkg::BK_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = front_ff + fill_ff[PW-1:0];
            ram_wdata = fill_value_ff;
            fill_in   = fill_ff + CW'(1);
            if (fill_in == target_ff) begin
               count_in     = target_ff;
               rsp_valid_in = 1'b1;
               state_in     = deq_pkg::BK_IDLE;
            end
         end
         default: state_in = deq_pkg::BK_IDLE;
      endcase

      rsp_in.read_value = (state_ff == deq_pkg::BK_READ) ? ram_rdata : '0;
      rsp_in.status     = status;
      rsp_in.count      = count_in;
      rsp_in.is_empty   = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::BK_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff       <= fill_in;
      target_ff     <= target_in;
      fill_value_ff <= fill_value_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DEQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(deq_pkg::DEPTH),
      "element count above capacity")
   `DEQ_ASSERT(a_fill_bound, clock, reset,
      state_ff != deq_pkg::BK_FILL || (fill_ff < target_ff && target_ff > count_ff),
      "fill walk outside new range")
   `DEQ_ASSERT_NEXT(a_read_result, clock, reset, state_ff == deq_pkg::BK_READ,
      rsp_valid_ff && rsp_ff.status == deq_pkg::ST_OK && $stable(count_ff),
      "read did not complete with a result")

endmodule

`default_nettype wire

### src/double_ended_queue.sv
// Top level of the double-ended queue: front end, back end and entry RAM.
// Depends on deq_pkg, deq_front and deq_back.
//
// One transaction in names one operation; exactly one result comes back per
// transaction, in order, on rsp_data for a single cycle with rsp_valid high.
// The receiver cannot stall, so results must be taken when they appear.
// An accepted transaction is written into the command queue; its result is
// registered once the back end executes it. A successful read also waits on
// the registered RAM read, and a growing resize waits while the single RAM
// write port fills one entry per cycle. Push, pop, failed reads, shrinking
// resize and clear retire at one per cycle while the back end is idle. A two-entry
// command queue sits between front and back end; busy is high while it is full.
`default_nettype none

module double_ended_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire deq_pkg::req_type req_data,
   output logic                  rsp_valid,
   output deq_pkg::rsp_type      rsp_data
);

   deq_pkg::cmd_link_type link;
   logic                  cmd_pop;

   deq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .link     (link),
      .cmd_pop  (cmd_pop)
   );

   deq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .link      (link),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### tb/deq_checker.sv
// Scoreboard for the double-ended queue: watches both channels, predicts each result.
// Depends on deq_pkg.
module deq_checker
   import deq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_data,
   output int                   mismatches,
   output int                   outstanding,
   output int                   checked,
   output int                   error_results,
   output int                   peak_level,
   output logic [CNT_WIDTH-1:0] level
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DATA_WIDTH-1:0] entries [DEPTH];
   logic [PTR_WIDTH-1:0]  head;
   rsp_type               pending_rsp_q [$];

   function automatic logic [PTR_WIDTH-1:0] slot_of(int unsigned offset);
      return PTR_WIDTH'(head + offset);
   endfunction

   function automatic rsp_type apply_op(req_type t);
      rsp_type r;
      r = '0;
      r.status = ST_OK;
      case (t.operation)
         OP_PUSH_FRONT: begin
            if (level == CNT_WIDTH'(DEPTH)) begin
               r.status = ST_FULL;
            end else begin
               head = head - PTR_WIDTH'(1);
               entries[head] = t.value;
               level = level + CNT_WIDTH'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (level == CNT_WIDTH'(DEPTH)) begin
               r.status = ST_FULL;
            end else begin
               entries[slot_of(level)] = t.value;
               level = level + CNT_WIDTH'(1);
            end
         end
         OP_POP_FRONT: begin
            if (level == '0) begin
               r.status = ST_EMPTY;
            end else begin
               head = slot_of(1);
               level = level - CNT_WIDTH'(1);
            end
         end
         OP_POP_BACK: begin
            if (level == '0) r.status = ST_EMPTY;
            else level = level - CNT_WIDTH'(1);
         end
         OP_READ_FRONT: begin
            if (level == '0) r.status = ST_EMPTY;
            else r.read_value = entries[head];
         end
         OP_READ_BACK: begin
            if (level == '0) r.status = ST_EMPTY;
            else r.read_value = entries[slot_of(level - CNT_WIDTH'(1))];
         end
         OP_READ_INDEX: begin
            if (level == '0) r.status = ST_EMPTY;
            else if (t.index >= level) r.status = ST_RANGE;
            else r.read_value = entries[slot_of(t.index)];
         end
         OP_RESIZE: begin
            if (t.index > CNT_WIDTH'(DEPTH)) begin
               r.status = ST_FULL;
            end else begin
               for (int unsigned i = level; i < t.index; i++) entries[slot_of(i)] = t.value;
               level = t.index;
            end
         end
         OP_CLEAR: level = '0;
         default: ;
      endcase
      r.count = level;
      r.is_empty = (level == '0);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp;
      if (reset) begin
         head = '0;
         level = '0;
         pending_rsp_q.delete();
         mismatches = 0;
         checked = 0;
         error_results = 0;
         peak_level = 0;
      end else begin
         if (rsp_valid) begin
            if (pending_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: result with no transaction pending: %p", $realtime, rsp_data);
            end else begin
               exp = pending_rsp_q[0];
               pending_rsp_q.delete(0);
               checked++;
               if (rsp_data.read_value !== exp.read_value || rsp_data.status !== exp.status ||
                   rsp_data.count !== exp.count || rsp_data.is_empty !== exp.is_empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%t: result %0d: expected value %h status %0d count %0d ",
                               "empty %b, got value %h status %0d count %0d empty %b"},
                              $realtime, checked, exp.read_value, exp.status, exp.count,
                              exp.is_empty, rsp_data.read_value, rsp_data.status,
                              rsp_data.count, rsp_data.is_empty);
               end
            end
         end
         if (start && !busy) begin
            exp = apply_op(req_data);
            pending_rsp_q = {pending_rsp_q, exp};
            if (exp.status != ST_OK) error_results++;
            if (int'(level) > peak_level) peak_level = int'(level);
         end
      end
      outstanding = pending_rsp_q.size();
   end

endmodule

### tb/testbench.sv
// Top of the double-ended queue testbench: clock, reset, stimulus and verdict.
// Depends on deq_pkg, double_ended_queue and deq_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import deq_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   int                   mismatches;
   int                   outstanding;
   int                   checked;
   int                   error_results;
   int                   peak_level;
   logic [CNT_WIDTH-1:0] level;
   bit                   dense = 1'b0;

   always #5 clock = ~clock;

   double_ended_queue u_dut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_data,
      .rsp_valid,
      .rsp_data
   );

   deq_checker u_checker (
      .clock,
      .reset,
      .start,
      .busy,
      .req_data,
      .rsp_valid,
      .rsp_data,
      .mismatches,
      .outstanding,
      .checked,
      .error_results,
      .peak_level,
      .level
   );

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic issue(input logic [OP_WIDTH-1:0] op, input logic [DATA_WIDTH-1:0] value,
                        input logic [CNT_WIDTH-1:0] index);
      int gap;
      gap = dense ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{operation: op, value: value, index: index};
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   initial begin
      int                    pick;
      int                    ceiling;
      logic [OP_WIDTH-1:0]   op;
      logic [DATA_WIDTH-1:0] val;
      logic [CNT_WIDTH-1:0]  idx;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue(OP_READ_FRONT, '0, '0);
      issue(OP_POP_BACK, '0, '0);
      issue(OP_POP_FRONT, '0, '0);
      issue(OP_READ_INDEX, '0, '0);
      issue(OP_PUSH_BACK, '1, '0);
      issue(OP_PUSH_FRONT, '0, '0);
      issue(OP_PUSH_BACK, 32'ha5a5_5a5a, '1);
      issue(OP_READ_FRONT, '0, '0);
      issue(OP_READ_BACK, '0, '0);
      issue(OP_READ_INDEX, '0, 11'd1);
      issue(OP_READ_INDEX, '0, 11'd3);
      issue(OP_READ_INDEX, '0, '1);
      issue(OP_POP_FRONT, '0, '0);
      issue(OP_POP_BACK, '0, '0);
      issue(OP_RESIZE, 32'h1234_5678, CNT_WIDTH'(DEPTH));
      issue(OP_PUSH_FRONT, 32'hdead_beef, '0);
      issue(OP_PUSH_BACK, 32'hdead_beef, '0);
      issue(OP_READ_INDEX, '0, CNT_WIDTH'(DEPTH - 1));
      issue(OP_RESIZE, '1, '1);
      issue(OP_RESIZE, '1, CNT_WIDTH'(DEPTH + 1));
      issue(OP_RESIZE, '0, 11'd5);
      issue(OP_READ_BACK, '0, '0);
      issue(OP_CLEAR, '0, '0);
      issue(OP_PUSH_BACK, 32'h0bad_f00d, '0);
      issue(OP_RESIZE, '0, '0);
      issue(OP_WIDTH'(int'(OP_CLEAR) + 1), '1, '1);
      issue(OP_WIDTH'((1 << OP_WIDTH) - 1), '1, '1);

      for (int n = 0; n < 1650; n++) begin
         if ($urandom_range(0, 99) == 0) dense = ~dense;
         pick = $urandom_range(0, 99);
         val = $urandom;
         idx = CNT_WIDTH'($urandom_range(0, (1 << CNT_WIDTH) - 1));
         if (pick < 18) begin
            op = OP_PUSH_FRONT;
         end else if (pick < 36) begin
            op = OP_PUSH_BACK;
         end else if (pick < 46) begin
            op = OP_POP_FRONT;
         end else if (pick < 56) begin
            op = OP_POP_BACK;
         end else if (pick < 62) begin
            op = OP_READ_FRONT;
         end else if (pick < 68) begin
            op = OP_READ_BACK;
         end else if (pick < 80) begin
            op = OP_READ_INDEX;
            if (level != 0 && $urandom_range(0, 3) != 0)
               idx = CNT_WIDTH'($urandom_range(0, level - 1));
         end else if (pick < 91) begin
            op = OP_RESIZE;
            case ($urandom_range(0, 19))
               0: idx = CNT_WIDTH'($urandom_range(DEPTH + 1, (1 << CNT_WIDTH) - 1));
               1: idx = CNT_WIDTH'($urandom_range(DEPTH - 8, DEPTH));
               default: begin
                  ceiling = int'(level) + 24;
                  if (ceiling > DEPTH) ceiling = DEPTH;
                  idx = CNT_WIDTH'($urandom_range(0, ceiling));
               end
            endcase
         end else if (pick < 95) begin
            op = OP_CLEAR;
         end else if (pick < 97) begin
            op = OP_WIDTH'($urandom_range(int'(OP_CLEAR) + 1, (1 << OP_WIDTH) - 1));
         end else begin
            op = OP_READ_INDEX;
         end
         issue(op, val, idx);
      end

      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("%0d transactions checked, %0d ended with an error status", checked, error_results);
      $display("deque held at most %0d of %0d entries", peak_level, DEPTH);
      if (mismatches == 0 && outstanding == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("timeout with %0d results outstanding", outstanding);
      $display("testbench NOT OK");
      $finish;
   end

endmodule
